// ----- rtl/sjis_pkg.sv -----
// ----------------------------------------------------------------------------
// sjis_pkg
// Shared types and constants for the Shift_JIS stream decoder.
// ----------------------------------------------------------------------------
package sjis_pkg;

  // Result kind codes, carried on out_tuser
  typedef enum logic [2:0] {
    KIND_ASCII    = 3'd0,
    KIND_KANA     = 3'd1,
    KIND_JIS      = 3'd2,
    KIND_EXT      = 3'd3,
    KIND_BAD_BYTE = 3'd4,
    KIND_BAD_PAIR = 3'd5
  } kind_t;

  // Which lead byte class is held
  typedef enum logic [1:0] {
    MODE_NONE = 2'd0,
    MODE_LOW  = 2'd1,
    MODE_HIGH = 2'd2,
    MODE_EXT  = 2'd3
  } mode_t;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CODE_W = 16;

  // Row/cell arithmetic constants
  localparam logic [7:0] LOW_LEAD_BASE  = 8'h81;
  localparam logic [7:0] HIGH_LEAD_BASE = 8'hc1;
  localparam logic [7:0] LEAD_SPLIT     = 8'ha0;
  localparam logic [7:0] ROW_OFFSET     = 8'h21;
  localparam logic [7:0] TRAIL_SPLIT    = 8'h9f;
  localparam logic [7:0] TRAIL_GAP      = 8'h7e;
  localparam logic [7:0] CELL_ADJ_HI    = 8'h20;
  localparam logic [7:0] CELL_ADJ_LO    = 8'h1f;
  localparam logic [7:0] CELL_ADJ_EVEN  = 8'h7e;

  // One accepted input item
  typedef struct packed {
    logic [BYTE_W-1:0] in_byte;
    logic              flush;
  } item_t;

  // Decode result handed to the output register
  typedef struct packed {
    logic              emit;
    kind_t             kind;
    logic [CODE_W-1:0] code;
  } result_t;

endpackage

// ----- rtl/sjis_in_reg.sv -----
// ----------------------------------------------------------------------------
// sjis_in_reg
// Input register: captures one item per transfer and holds it until the
// decode stage consumes it.
// ----------------------------------------------------------------------------
module sjis_in_reg (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  sjis_pkg::item_t in_item,
  input  logic           advance,   // downstream can take the held item
  output logic           held_fire, // held item is consumed this cycle
  output sjis_pkg::item_t held_item
);
  import sjis_pkg::*;

  logic  valid_r, valid_nxt;
  item_t item_r;

  assign held_fire = valid_r && advance;
  assign in_ready  = !valid_r || advance;
  assign held_item = item_r;

  // Occupancy: refill on transfer, drain on consume
  always_comb begin
    valid_nxt = valid_r;
    if (in_ready) begin
      valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_item;
    end
  end

endmodule

// ----- rtl/sjis_decode.sv -----
// ----------------------------------------------------------------------------
// sjis_decode
// Byte classifier with the held lead byte; turns lead/trail pairs into JIS X
// 0208 row/cell codes, extension (0xf0-0xfc) and bad pairs into raw bytes.
// ----------------------------------------------------------------------------
module sjis_decode (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  sjis_pkg::item_t   item,
  output sjis_pkg::result_t res
);
  import sjis_pkg::*;

  logic [7:0] lead_r, lead_nxt;
  mode_t      mode_r, mode_nxt;

  logic [7:0] b;
  logic       trail_ok;
  logic [7:0] row_base;
  logic [7:0] row_even;
  logic [7:0] row;
  logic [7:0] cell_val;

  assign b = item.in_byte;

  // Trail range 0x40-0x7e, 0x80-0xfc
  assign trail_ok = (b >= 8'h40 && b <= 8'h7e) || (b >= 8'h80 && b <= 8'hfc);

  // Pair to row/cell
  always_comb begin
    row_base = (lead_r < LEAD_SPLIT) ? (lead_r - LOW_LEAD_BASE) : (lead_r - HIGH_LEAD_BASE);
    row_even = {row_base[6:0], 1'b0} + ROW_OFFSET;
    if (b < TRAIL_SPLIT) begin
      row      = row_even;
      cell_val = b - ((b > TRAIL_GAP) ? CELL_ADJ_HI : CELL_ADJ_LO);
    end else begin
      row      = row_even + 8'd1;
      cell_val = b - CELL_ADJ_EVEN;
    end
  end

  // Classification and lead tracking
  always_comb begin
    lead_nxt = lead_r;
    mode_nxt = mode_r;
    res.emit = 1'b0;
    res.kind = KIND_ASCII;
    res.code = {8'h00, b};
    if (item.flush) begin
      res.kind = KIND_BAD_BYTE;
      res.code = {8'h00, lead_r};
      res.emit = (mode_r != MODE_NONE);
      mode_nxt = MODE_NONE;
    end else if (mode_r != MODE_NONE) begin
      mode_nxt = MODE_NONE;
      res.emit = 1'b1;
      if (!trail_ok) begin
        res.kind = KIND_BAD_PAIR;
        res.code = {lead_r, b};
      end else if (mode_r == MODE_EXT) begin
        res.kind = KIND_EXT;
        res.code = {lead_r, b};
      end else begin
        res.kind = KIND_JIS;
        res.code = {row, cell_val};
      end
    end else begin
      unique case (b) inside
        [8'h00:8'h7f]: begin
          res.emit = 1'b1;
          res.kind = KIND_ASCII;
        end
        [8'h81:8'h9f]: begin
          lead_nxt = b;
          mode_nxt = MODE_LOW;
        end
        [8'he0:8'hef]: begin
          lead_nxt = b;
          mode_nxt = MODE_HIGH;
        end
        [8'hf0:8'hfc]: begin
          lead_nxt = b;
          mode_nxt = MODE_EXT;
        end
        [8'ha1:8'hdf]: begin
          res.emit = 1'b1;
          res.kind = KIND_KANA;
        end
        default: begin
          res.emit = 1'b1;
          res.kind = KIND_BAD_BYTE;
        end
      endcase
    end
  end

  // Held lead state, updated only when an item is consumed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lead_r <= 8'h00;
      mode_r <= MODE_NONE;
    end else if (fire) begin
      lead_r <= lead_nxt;
      mode_r <= mode_nxt;
    end
  end

endmodule

// ----- rtl/sjis_out_reg.sv -----
// ----------------------------------------------------------------------------
// sjis_out_reg
// Result register: holds one decoded item until the sink takes it and
// tells the upstream stage when it may advance.
// ----------------------------------------------------------------------------
module sjis_out_reg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               fire,
  input  sjis_pkg::result_t  res,
  output logic               advance,
  output logic               out_valid,
  input  logic               out_ready,
  output sjis_pkg::kind_t    out_kind,
  output logic [sjis_pkg::CODE_W-1:0] out_code
);
  import sjis_pkg::*;

  logic              valid_r, valid_nxt;
  kind_t             kind_r;
  logic [CODE_W-1:0] code_r;

  // Free when empty or emptying this cycle
  assign advance   = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_kind  = kind_r;
  assign out_code  = code_r;

  always_comb begin
    valid_nxt = valid_r;
    if (advance) begin
      valid_nxt = fire && res.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && fire && res.emit) begin
      kind_r <= res.kind;
      code_r <= res.code;
    end
  end

endmodule

// ----- rtl/shift_jis_stream_decoder.sv -----
// ----------------------------------------------------------------------------
// shift_jis_stream_decoder
// Shift_JIS byte stream to ASCII / half-width kana / JIS X 0208 items.
//
//   channel | direction | tdata            | tuser     | tlast
//   in_     | slave     | [7:0] in_byte    | -         | flush
//   out_    | master    | [15:0] code      | [2:0] kind| -
//
// One byte per clock sustained while out_tready does not stall; an item goes
// from the input register through combinational decode into the result
// register. A lead byte gives no result; the pair's result comes
// with the trail byte. Reset clears both registers and the held lead.
// A stall on out_tready backs up through the input register to in_tready.
// ----------------------------------------------------------------------------
module shift_jis_stream_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte
  input  logic        in_tlast,   // flush
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] code
  output logic [2:0]  out_tuser   // [2:0] kind
);
  import sjis_pkg::*;

  item_t   in_item;
  item_t   held_item;
  logic    held_fire;
  logic    advance;
  result_t res;
  kind_t   out_kind;

  assign in_item.in_byte = in_tdata;
  assign in_item.flush   = in_tlast;

  // Input register
  sjis_in_reg u_in_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_item   (in_item),
    .advance   (advance),
    .held_fire (held_fire),
    .held_item (held_item)
  );

  // Decode with held lead
  sjis_decode u_decode (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (held_fire),
    .item  (held_item),
    .res   (res)
  );

  // Result register
  sjis_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (held_fire),
    .res       (res),
    .advance   (advance),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_kind  (out_kind),
    .out_code  (out_tdata)
  );

  assign out_tuser = out_kind;

endmodule

// ----- rtl/sjis_checker.sv -----
// ----------------------------------------------------------------------------
// sjis_checker
// Port-level assertions for the Shift_JIS stream decoder.
// ----------------------------------------------------------------------------
module sjis_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic [2:0]  out_tuser
);
  import sjis_pkg::*;

  // Nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // Single-byte kinds carry a zero upper byte
  a_single_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == KIND_ASCII || out_tuser == KIND_KANA ||
                   out_tuser == KIND_BAD_BYTE) |-> out_tdata[15:8] == 8'h00)
    else $error("single-byte result with nonzero upper byte");

  // JIS row and cell both in 0x21-0x7e
  a_jis_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_JIS |->
      out_tdata[15:8] >= 8'h21 && out_tdata[15:8] <= 8'h7e &&
      out_tdata[7:0] >= 8'h21 && out_tdata[7:0] <= 8'h7e)
    else $error("JIS row/cell out of range");

  // Extension pairs start with a lead 0xf0-0xfc
  a_ext_lead: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_EXT |->
      out_tdata[15:8] >= 8'hf0 && out_tdata[15:8] <= 8'hfc)
    else $error("extension pair with wrong lead");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

endmodule

bind shift_jis_stream_decoder sjis_checker u_sjis_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
